FILE: src/pidf_pkg.sv
// Package for the PNG IDAT chunk framer: result kinds, constants and the CRC-32 byte step.
package pidf_pkg;

	typedef enum logic [1:0] {
		KIND_LEN  = 2'd0,
		KIND_TYPE = 2'd1,
		KIND_DATA = 2'd2,
		KIND_CRC  = 2'd3
	} kind_t;

	localparam int unsigned LenW = 31;

	localparam logic [31:0] TYPE_WORD = 32'h4944_4154;  // "IDAT"
	localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ONES  = 32'hFFFF_FFFF;

	// reflected CRC-32, one byte, LSB first
	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = CRC_POLY ^ (c >> 1);
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// running CRC after the four type bytes, from preset
	localparam logic [31:0] TYPE_CRC = crc_byte(crc_byte(crc_byte(crc_byte(CRC_ONES,
		TYPE_WORD[31:24]), TYPE_WORD[23:16]), TYPE_WORD[15:8]), TYPE_WORD[7:0]);

endpackage

FILE: src/png_idat_chunk_framer.sv
// PNG IDAT chunk framer: cuts a compressed byte stream into IDAT chunks with length, type and CRC.
//
// Usage:
//   Write the stream length on cfg_wr_en/cfg_wr_data while the block is idle; this
//   restarts framing. Bytes then arrive on the s_axis word channel, one byte per word.
//   For every accepted byte the m_axis channel delivers one to four words: the length
//   word and the 'IDAT' type word when the byte opens a chunk, the data byte itself,
//   and the CRC-32 word when the byte closes a chunk. m_axis_tlast marks the last word
//   caused by a byte; m_axis_tuser carries the word kind and the end-of-stream flag.
//   Bytes past the configured length are taken and dropped without output.
// Timing:
//   An accepted byte sits in one input register; its first word then moves into
//   the output register, which drives tvalid. One byte per cycle inside a chunk
//   while m_axis_tready is high; the input register is held until its last word has
//   moved on, also the length and type words of an opening byte and the CRC word of
//   a closing one. The CRC update of one byte is done in the accept cycle.
// Reset and stall:
//   arst_n clears both registers' valid flags and sets the length to zero (no chunks).
//   When m_axis_tready is low, the output word holds and s_axis_tready drops as soon as
//   the input register is occupied.
module png_idat_chunk_framer
	import pidf_pkg::*;
#(
	parameter int unsigned CHUNK_MAX = 8192
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  logic [7:0]      s_axis_tdata,   // [7:0] data_byte
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [31:0]     m_axis_tdata,   // [31:0] value
	output logic            m_axis_tlast,   // run_last
	output logic [2:0]      m_axis_tuser,   // [1:0] kind, [2] stream_done
	input  logic            cfg_wr_en,
	input  logic [LenW-1:0] cfg_wr_data     // total_length
);

	localparam int unsigned CntW = $clog2(CHUNK_MAX + 1);

	// framing state
	logic [LenW-1:0] bytes_left_q;
	logic [CntW-1:0] chunk_left_q;
	logic [31:0]     crc_q;

	// input stage: one byte and everything needed to emit its words
	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            first_s1;
	logic            last_s1;
	logic            done_s1;
	logic [CntW-1:0] len_s1;
	logic [31:0]     crc_s1;
	kind_t           phase_q;

	// output register
	logic        m_valid_q;
	logic [31:0] m_value_q;
	kind_t       m_kind_q;
	logic        m_last_q;
	logic        m_done_q;

	// accept-side logic
	logic            in_fire;
	logic            take_byte;
	logic            first_c;
	logic [CntW-1:0] size_c;
	logic [CntW-1:0] chunk_eff_c;
	logic [CntW-1:0] chunk_next_c;
	logic [31:0]     crc_new_c;
	logic            last_c;

	// emit-side logic
	logic  out_free;
	logic  final_phase;
	kind_t phase_next;
	logic [31:0] emit_value;
	logic        emit_last;
	logic        emit_done;

	assign out_free    = !m_valid_q || m_axis_tready;
	assign final_phase = last_s1 ? (phase_q == KIND_CRC) : (phase_q == KIND_DATA);
	assign s_axis_tready = !valid_s1 || (out_free && final_phase);
	assign in_fire     = s_axis_tvalid && s_axis_tready;
	assign take_byte   = in_fire && (bytes_left_q != '0);

	always_comb begin
		first_c = (chunk_left_q == '0);
		if (bytes_left_q > LenW'(CHUNK_MAX)) begin
			size_c = CntW'(CHUNK_MAX);
		end else begin
			size_c = bytes_left_q[CntW-1:0];
		end
		chunk_eff_c  = first_c ? size_c : chunk_left_q;
		chunk_next_c = chunk_eff_c - CntW'(1);
		last_c       = (chunk_next_c == '0);
		// a new chunk starts from the CRC already run over the type word
		crc_new_c    = crc_byte(first_c ? TYPE_CRC : crc_q, s_axis_tdata);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			chunk_left_q <= '0;
			crc_q        <= CRC_ONES;
		end else if (cfg_wr_en) begin
			bytes_left_q <= cfg_wr_data;
			chunk_left_q <= '0;
			crc_q        <= CRC_ONES;
		end else if (take_byte) begin
			bytes_left_q <= bytes_left_q - LenW'(1);
			chunk_left_q <= chunk_next_c;
			crc_q        <= crc_new_c;
		end
	end

	// input register; freed when its final word enters the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= KIND_DATA;
		end else if (s_axis_tready) begin
			valid_s1 <= take_byte;
			phase_q  <= first_c ? KIND_LEN : KIND_DATA;
		end else if (out_free) begin
			phase_q <= phase_next;
		end
	end

	always_ff @(posedge clk) begin
		if (take_byte) begin
			byte_s1  <= s_axis_tdata;
			first_s1 <= first_c;
			last_s1  <= last_c;
			done_s1  <= last_c && (bytes_left_q == LenW'(1));
			len_s1   <= chunk_eff_c;
			crc_s1   <= crc_new_c ^ CRC_ONES;
		end
	end

	always_comb begin
		unique case (phase_q)
			KIND_LEN: begin
				phase_next = KIND_TYPE;
				emit_value = 32'(len_s1);
				emit_last  = 1'b0;
				emit_done  = 1'b0;
			end
			KIND_TYPE: begin
				phase_next = KIND_DATA;
				emit_value = TYPE_WORD;
				emit_last  = 1'b0;
				emit_done  = 1'b0;
			end
			KIND_DATA: begin
				phase_next = KIND_CRC;
				emit_value = {24'd0, byte_s1};
				emit_last  = !last_s1;
				emit_done  = 1'b0;
			end
			KIND_CRC: begin
				phase_next = KIND_DATA;
				emit_value = crc_s1;
				emit_last  = 1'b1;
				emit_done  = done_s1;
			end
			default: begin
				phase_next = KIND_DATA;
				emit_value = '0;
				emit_last  = 1'b0;
				emit_done  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			m_value_q <= emit_value;
			m_kind_q  <= phase_q;
			m_last_q  <= emit_last;
			m_done_q  <= emit_done;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_value_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tuser  = {m_done_q, m_kind_q};

	// a chunk never runs past the end of the stream
	a_chunk_in_stream: assert property (@(posedge clk) disable iff (!arst_n)
		(chunk_left_q <= CntW'(bytes_left_q)) || (bytes_left_q > LenW'(CHUNK_MAX)))
		else $error("chunk extends beyond stream end");

	// header phases only for a byte that opens a chunk
	a_header_first: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (phase_q == KIND_LEN || phase_q == KIND_TYPE) |-> first_s1)
		else $error("header word for a byte inside a chunk");

	// CRC phase only for a byte that closes a chunk
	a_crc_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (phase_q == KIND_CRC) |-> last_s1)
		else $error("crc word for a byte inside a chunk");

	// end of stream only on a closing CRC word
	a_done_on_crc: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_done_q |-> m_last_q && (m_kind_q == KIND_CRC))
		else $error("stream_done outside a closing crc word");

endmodule

FILE: tb/sv/tb_top.sv
// Testbench for png_idat_chunk_framer: random byte streams checked word by word against a predictor.
`timescale 1ns / 1ps

module tb_top
	import pidf_pkg::*;
;

	localparam int unsigned CHUNK_MAX    = 8192;
	localparam int          ITEMS        = 200;   // random stream bytes that get framed
	localparam int          DRAIN_CYCLES = 8;     // pipeline is two registers deep
	localparam int          STALL_LIMIT  = 1000;  // cycles with no word moving

	// one output word as the m_axis side sees it
	typedef struct packed {
		kind_t       kind;
		logic [31:0] value;
		logic        last;
		logic        done;
	} idat_word_t;

	// Predicts the framer and holds the words still owed by the block.
	class idat_scoreboard;
		logic [LenW-1:0] bytes_left;
		logic [13:0]     chunk_left;
		logic [31:0]     crc;
		idat_word_t      expected_words[$];
		int              errors;

		function new();
			restart('0);
			errors = 0;
		endfunction

		// reflected CRC-32, one byte, bit by bit
		function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
			logic [31:0] r;
			r = c ^ {24'd0, b};
			for (int i = 0; i < 8; i++) begin
				r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
			end
			return r;
		endfunction

		// a length write restarts the stream
		function void restart(logic [LenW-1:0] len);
			bytes_left = len;
			chunk_left = '0;
			crc        = CRC_ONES;
		endfunction

		function void note_byte(logic [7:0] b);
			logic [13:0] sz;
			logic        opens;
			logic        closes;
			logic        stream_end;
			logic [31:0] crc_out;
			if (bytes_left == '0) begin
				return;   // past the end of the stream: dropped
			end
			opens = (chunk_left == '0);
			sz    = '0;
			if (opens) begin
				sz         = (bytes_left > CHUNK_MAX) ? 14'(CHUNK_MAX) : bytes_left[13:0];
				chunk_left = sz;
				crc        = CRC_ONES;
				for (int i = 3; i >= 0; i--) begin
					crc = crc_step(crc, TYPE_WORD[8*i +: 8]);
				end
			end
			crc        = crc_step(crc, b);
			chunk_left = chunk_left - 14'd1;
			bytes_left = bytes_left - 1'b1;
			closes     = (chunk_left == '0);
			stream_end = (bytes_left == '0);
			crc_out    = crc ^ CRC_ONES;
			if (closes) begin
				crc = CRC_ONES;
			end
			if (opens) begin
				expected_words.push_back('{KIND_LEN, {18'd0, sz}, 1'b0, 1'b0});
				expected_words.push_back('{KIND_TYPE, TYPE_WORD, 1'b0, 1'b0});
			end
			expected_words.push_back('{KIND_DATA, {24'd0, b}, !closes, 1'b0});
			if (closes) begin
				expected_words.push_back('{KIND_CRC, crc_out, 1'b1, stream_end});
			end
		endfunction

		task report(string msg);
			$display("MISMATCH %s", msg);
			errors++;
		endtask

		task check_word(idat_word_t got);
			idat_word_t want;
			if (expected_words.size() == 0) begin
				report($sformatf("unexpected word kind %0d value %h", got.kind, got.value));
				return;
			end
			want = expected_words.pop_front();
			if (got.kind != want.kind)
				report($sformatf("kind got %0d exp %0d", got.kind, want.kind));
			if (got.value != want.value)
				report($sformatf("value got %h exp %h (kind %0d)", got.value, want.value,
					want.kind));
			if (got.last != want.last)
				report($sformatf("tlast got %b exp %b (kind %0d)", got.last, want.last,
					want.kind));
			if (got.done != want.done)
				report($sformatf("stream_done got %b exp %b (kind %0d)", got.done, want.done,
					want.kind));
		endtask
	endclass

	logic            clk = 1'b0;
	logic            arst_n;
	logic            s_axis_tvalid;
	logic            s_axis_tready;
	logic [7:0]      s_axis_tdata;    // [7:0] data_byte
	logic            m_axis_tvalid;
	logic            m_axis_tready;
	logic [31:0]     m_axis_tdata;    // [31:0] value
	logic            m_axis_tlast;    // run_last
	logic [2:0]      m_axis_tuser;    // [1:0] kind, [2] stream_done
	logic            cfg_wr_en;
	logic [LenW-1:0] cfg_wr_data;     // total_length

	idat_scoreboard board = new();
	bit             idle_on;          // per stream: both sides may insert gaps
	int             moves;            // words moved on either side
	int             last_moves;
	int             stall_cycles;
	int             framed_bytes;

	png_idat_chunk_framer #(
		.CHUNK_MAX(CHUNK_MAX)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Drives are applied at the falling edge; handshakes are sampled at the rising edge.
	// Each task starts and ends at a falling edge.
	task automatic feed_byte(input logic [7:0] b);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap != 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = b;
		do @(posedge clk); while (!s_axis_tready);
		board.note_byte(b);
		moves++;
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	// Waits until the block is idle, then writes a new stream length.
	// Dropped bytes leave no expectation behind, so the task also waits DRAIN_CYCLES to let them clear.
	task automatic set_length(input logic [LenW-1:0] len);
		while (board.expected_words.size() != 0) @(negedge clk);
		s_axis_tvalid = 1'b0;
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = len;
		@(posedge clk);
		board.restart(len);
		@(negedge clk);
		cfg_wr_en = 1'b0;
		idle_on   = ($urandom_range(0, 3) != 0);
	endtask

	// m_axis sink: random ready gaps per word, every accepted word goes to the checker
	initial begin
		idat_word_t got;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			int gap;
			gap = idle_on ? $urandom_range(0, 3) : 0;
			if (gap != 0) begin
				m_axis_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got.kind  = kind_t'(m_axis_tuser[1:0]);
			got.value = m_axis_tdata;
			got.last  = m_axis_tlast;
			got.done  = m_axis_tuser[2];
			board.check_word(got);
			moves++;
			@(negedge clk);
		end
	end

	// watchdog: ends the run when no word moves for too long
	always @(negedge clk) begin
		if (arst_n) begin
			if (moves != last_moves) begin
				last_moves   = moves;
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		int          pick;
		int          nbytes;
		logic [LenW-1:0] len;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		idle_on       = 1'b1;
		moves         = 0;
		last_moves    = 0;
		stall_cycles  = 0;
		framed_bytes  = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// after reset the length is zero: everything is dropped
		feed_byte(8'h00);
		feed_byte(8'hFF);
		// empty stream written explicitly
		set_length('0);
		feed_byte(8'h5A);
		// one-byte chunk, closes the stream; the next byte is past the end
		set_length(31'd1);
		feed_byte(8'hFF);
		feed_byte(8'h00);
		// short chunk with edge byte values
		set_length(31'd5);
		feed_byte(8'h00);
		feed_byte(8'h01);
		feed_byte(8'h80);
		feed_byte(8'h7F);
		feed_byte(8'hFF);
		// largest length: chunk length saturates at CHUNK_MAX, stream cut short
		set_length(31'h7FFF_FFFF);
		feed_byte(8'hA5);
		feed_byte(8'h5A);
		feed_byte(8'h3C);
		set_length(31'd2);
		feed_byte(8'h12);
		feed_byte(8'h34);

		// random streams: mostly complete ones, some cut short, some empty or overrun
		while (framed_bytes < ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				len    = '0;
				nbytes = $urandom_range(1, 3);
			end else if (pick == 1) begin
				len    = 31'($urandom);
				nbytes = $urandom_range(1, 8);
			end else begin
				len    = 31'($urandom_range(1, 24));
				nbytes = int'(len);
				if ($urandom_range(0, 3) == 0)
					nbytes += $urandom_range(1, 2);
				else if ($urandom_range(0, 7) == 0)
					nbytes = $urandom_range(1, int'(len));
			end
			set_length(len);
			for (int i = 0; i < nbytes; i++) begin
				feed_byte(8'($urandom_range(0, 255)));
				if (i < len)
					framed_bytes++;
			end
		end

		while (board.expected_words.size() != 0) @(negedge clk);
		s_axis_tvalid = 1'b0;
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (board.errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
